### rtl/stsin_pkg.sv
// Shared types, widths and helpers for the Taylor-series sine block.
// Used by stsin_mul_unit, stsin_div_unit and sine_taylor_series.
package stsin_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int ANGLE_W       = 37;
    localparam int VAL_W         = 48;
    localparam int MAG_W         = VAL_W - 1;
    localparam int THR_W         = 32;
    localparam int LIM_W         = 16;
    localparam int DIV_W         = 2 * LIM_W + 2;
    localparam int OP_W          = 64;
    localparam int CHUNK_W       = OP_W / 2;
    localparam int PROD_W        = 2 * OP_W;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic REG_THR = 1'b0;
    localparam logic REG_LIM = 1'b1;

    localparam logic [THR_W-1:0] THR_RST = 32'd4295;
    localparam logic [LIM_W-1:0] LIM_RST = 16'd100;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_LAUNCH,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_FINISH
    } st_t;

    function automatic logic [OP_W-1:0] sat_shift(input logic [PROD_W-1:0] prod,
                                                 input int sh);
        logic [PROD_W-1:0] shifted;
        shifted = prod >> sh;
        if (|shifted[PROD_W-1:OP_W])
            sat_shift = {OP_W{1'b1}};
        else
            sat_shift = shifted[OP_W-1:0];
    endfunction

endpackage

### rtl/sine_taylor_series.sv
// Top level of the Taylor-series sine block: APB registers, sequencer, output register.
// Depends on stsin_pkg, stsin_mul_unit and stsin_div_unit.
//
// Each transaction carries one angle (fixed point, FRAC_BITS fraction bits) and returns the
// Maclaurin partial sum of sin, the number of series steps and a limit flag. The block works
// on one angle at a time and holds in_stall high until that angle's sum is finished; a
// finished result waits in the output register while the next angle is taken. Each series
// step (at most max_terms, or one when max_terms is zero) runs one pass of the shared
// multiplier, built on a 32x32 partial product, and then the bit-serial divider, which
// sets the step time. Registers: stop_threshold at byte address 0, max_terms at byte address 4.
module sine_taylor_series
#(
    parameter int FRAC_BITS = stsin_pkg::FRAC_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [stsin_pkg::ANGLE_W-1:0] angle,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [stsin_pkg::VAL_W-1:0]   series_sum,
    output logic [stsin_pkg::LIM_W-1:0]          steps_taken,
    output logic                                 hit_limit,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [stsin_pkg::ADDR_W-1:0]         paddr,
    input  logic [stsin_pkg::DATA_W-1:0]         pwdata,
    output logic [stsin_pkg::DATA_W-1:0]         prdata,
    output logic                                 pready
);

    localparam int SH_L = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
    localparam int SH_R = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 0;

    stsin_pkg::st_t state_reg;
    stsin_pkg::st_t state_next;

    logic [stsin_pkg::THR_W-1:0]          thr_reg;
    logic [stsin_pkg::LIM_W-1:0]          lim_reg;
    logic [stsin_pkg::LIM_W-1:0]          lim_eff;
    logic [stsin_pkg::OP_W-1:0]           eps;
    logic                                 cfg_wr;

    logic [stsin_pkg::OP_W-1:0]           h_reg;
    logic [stsin_pkg::MAG_W-1:0]          term_mag_reg;
    logic                                 term_neg_reg;
    logic [stsin_pkg::VAL_W-1:0]          sum_reg;
    logic [stsin_pkg::LIM_W-1:0]          k_reg;
    logic [stsin_pkg::DIV_W-1:0]          d_reg;
    logic [stsin_pkg::MAG_W-1:0]          q_reg;

    logic                                 out_valid_reg;
    logic [stsin_pkg::VAL_W-1:0]          sum_out_reg;
    logic [stsin_pkg::LIM_W-1:0]          steps_out_reg;
    logic                                 hit_out_reg;

    logic                                 in_acc;
    logic [stsin_pkg::ANGLE_W-1:0]        in_mag;
    logic                                 mul_start;
    logic [stsin_pkg::OP_W-1:0]           mul_a;
    logic [stsin_pkg::OP_W-1:0]           mul_b;
    logic                                 mul_busy;
    logic                                 mul_done;
    logic [stsin_pkg::PROD_W-1:0]         mul_prod;
    logic                                 div_start;
    logic                                 div_busy;
    logic                                 div_done;
    logic [stsin_pkg::OP_W-1:0]           div_quo;
    logic [stsin_pkg::MAG_W-1:0]          q_clamped;
    logic [stsin_pkg::VAL_W:0]            term_ext;
    logic [stsin_pkg::VAL_W:0]            sum_ext;
    logic [stsin_pkg::VAL_W-1:0]          sum_sat;
    logic                                 go_on;
    logic                                 out_load;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= stsin_pkg::THR_RST;
            lim_reg <= stsin_pkg::LIM_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                stsin_pkg::REG_THR: thr_reg <= pwdata;
                stsin_pkg::REG_LIM: lim_reg <= pwdata[stsin_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            stsin_pkg::REG_THR: prdata = thr_reg;
            stsin_pkg::REG_LIM: prdata = {{(stsin_pkg::DATA_W-stsin_pkg::LIM_W){1'b0}}, lim_reg};
            default:            prdata = '0;
        endcase
    end

    assign lim_eff = (lim_reg == '0) ? stsin_pkg::LIM_W'(1) : lim_reg;
    assign eps = ({{(stsin_pkg::OP_W-stsin_pkg::THR_W){1'b0}}, thr_reg} << SH_L) >> SH_R;

    // datapath helpers
    assign in_stall = (state_reg != stsin_pkg::ST_IDLE);
    assign in_acc   = in_valid & ~in_stall;
    assign in_mag   = angle[stsin_pkg::ANGLE_W-1] ? (~angle + 1'b1) : angle;

    always_comb
    begin
        if (state_reg == stsin_pkg::ST_IDLE)
        begin
            mul_a = {{(stsin_pkg::OP_W-stsin_pkg::ANGLE_W){1'b0}}, in_mag};
            mul_b = {{(stsin_pkg::OP_W-stsin_pkg::ANGLE_W){1'b0}}, in_mag};
        end
        else
        begin
            mul_a = {{(stsin_pkg::OP_W-stsin_pkg::MAG_W){1'b0}}, term_mag_reg};
            mul_b = h_reg;
        end
    end

    assign q_clamped = (|div_quo[stsin_pkg::OP_W-1:stsin_pkg::MAG_W]) ? stsin_pkg::MAG_MAX
                                                                    : div_quo[stsin_pkg::MAG_W-1:0];

    always_comb
    begin
        term_ext = term_neg_reg ? {2'b00, q_reg} : (~{2'b00, q_reg} + 1'b1);
        sum_ext  = {sum_reg[stsin_pkg::VAL_W-1], sum_reg} + term_ext;
        if (sum_ext[stsin_pkg::VAL_W] != sum_ext[stsin_pkg::VAL_W-1])
            sum_sat = sum_ext[stsin_pkg::VAL_W] ? stsin_pkg::VAL_MIN : stsin_pkg::VAL_MAX;
        else
            sum_sat = sum_ext[stsin_pkg::VAL_W-1:0];
        go_on = ({{(stsin_pkg::OP_W-stsin_pkg::MAG_W){1'b0}}, q_reg} > eps) && (k_reg < lim_eff);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= stsin_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            stsin_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    mul_start  = 1'b1;
                    state_next = stsin_pkg::ST_SQUARE;
                end
            end
            stsin_pkg::ST_SQUARE:
            begin
                if (mul_done)
                    state_next = stsin_pkg::ST_LAUNCH;
            end
            stsin_pkg::ST_LAUNCH:
            begin
                mul_start  = 1'b1;
                state_next = stsin_pkg::ST_MUL;
            end
            stsin_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = stsin_pkg::ST_DIV;
                end
            end
            stsin_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = stsin_pkg::ST_ACC;
            end
            stsin_pkg::ST_ACC:
            begin
                state_next = go_on ? stsin_pkg::ST_LAUNCH : stsin_pkg::ST_FINISH;
            end
            stsin_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = stsin_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stsin_pkg::ST_IDLE;
            end
        endcase
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            term_mag_reg <= {{(stsin_pkg::MAG_W-stsin_pkg::ANGLE_W){1'b0}}, in_mag};
            term_neg_reg <= angle[stsin_pkg::ANGLE_W-1];
            sum_reg      <= {{(stsin_pkg::VAL_W-stsin_pkg::ANGLE_W){angle[stsin_pkg::ANGLE_W-1]}},
                             angle};
            k_reg        <= '0;
            d_reg        <= '0;
        end
        if (state_reg == stsin_pkg::ST_SQUARE && mul_done)
            h_reg <= stsin_pkg::sat_shift(mul_prod, FRAC_BITS + 1);
        if (state_reg == stsin_pkg::ST_LAUNCH)
        begin
            k_reg <= k_reg + 1'b1;
            d_reg <= d_reg + {{(stsin_pkg::DIV_W-stsin_pkg::LIM_W-2){1'b0}}, k_reg, 2'b00}
                     + stsin_pkg::DIV_W'(3);
        end
        if (state_reg == stsin_pkg::ST_DIV && div_done)
            q_reg <= q_clamped;
        if (state_reg == stsin_pkg::ST_ACC)
        begin
            term_mag_reg <= q_reg;
            term_neg_reg <= ~term_neg_reg & (q_reg != '0);
            sum_reg      <= sum_sat;
        end
        if (out_load)
        begin
            sum_out_reg   <= sum_reg;
            steps_out_reg <= k_reg;
            hit_out_reg   <= (k_reg == lim_eff);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid   = out_valid_reg;
    assign series_sum  = sum_out_reg;
    assign steps_taken = steps_out_reg;
    assign hit_limit   = hit_out_reg;

    stsin_mul_unit u_mul
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .a        (mul_a),
        .b        (mul_b),
        .busy     (mul_busy),
        .done     (mul_done),
        .prod     (mul_prod)
    );

    stsin_div_unit u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (stsin_pkg::sat_shift(mul_prod, FRAC_BITS)),
        .divisor  (d_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_busy && div_busy))
        else $error("multiplier and divider busy together");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != stsin_pkg::ST_IDLE) |-> (k_reg <= lim_eff))
        else $error("step count beyond limit");

    a_limit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_out_reg) |-> (steps_out_reg == lim_eff))
        else $error("limit flag without full step count");

    a_divisor_live: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (d_reg != '0))
        else $error("divider started with zero divisor");

endmodule

### rtl/stsin_mul_unit.sv
// Shared 64x64 multiplier built from one registered 32x32 partial product.
// Four partial products, accumulated into a 128-bit register.
// Depends on stsin_pkg.
module stsin_mul_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [stsin_pkg::OP_W-1:0]     a,
    input  logic [stsin_pkg::OP_W-1:0]     b,
    output logic                           busy,
    output logic                           done,
    output logic [stsin_pkg::PROD_W-1:0]   prod
);

    localparam int NUM_PP = 4;

    logic                                 busy_reg;
    logic                                 done_reg;
    logic [2:0]                           cnt_reg;
    logic [stsin_pkg::OP_W-1:0]           a_reg;
    logic [stsin_pkg::OP_W-1:0]           b_reg;
    logic [stsin_pkg::OP_W-1:0]           pp_reg;
    logic [1:0]                           pp_sh_reg;
    logic [stsin_pkg::PROD_W-1:0]         acc_reg;
    logic [stsin_pkg::CHUNK_W-1:0]        a_chunk;
    logic [stsin_pkg::CHUNK_W-1:0]        b_chunk;
    logic [stsin_pkg::PROD_W-1:0]         pp_ext;

    always_comb
    begin
        a_chunk = cnt_reg[1] ? a_reg[stsin_pkg::OP_W-1:stsin_pkg::CHUNK_W]
                             : a_reg[stsin_pkg::CHUNK_W-1:0];
        b_chunk = cnt_reg[0] ? b_reg[stsin_pkg::OP_W-1:stsin_pkg::CHUNK_W]
                             : b_reg[stsin_pkg::CHUNK_W-1:0];
        pp_ext  = {{stsin_pkg::OP_W{1'b0}}, pp_reg} << (stsin_pkg::CHUNK_W * pp_sh_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'(NUM_PP))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    done_reg <= 1'b0;
            end
            else
                done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'(NUM_PP))
            begin
                pp_reg    <= a_chunk * b_chunk;
                pp_sh_reg <= 2'({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]});
            end
            if (cnt_reg != 3'd0)
                acc_reg <= acc_reg + pp_ext;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### rtl/stsin_div_unit.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 34-bit divisor.
// Depends on stsin_pkg.
module stsin_div_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [stsin_pkg::OP_W-1:0]     dividend,
    input  logic [stsin_pkg::DIV_W-1:0]    divisor,
    output logic                           busy,
    output logic                           done,
    output logic [stsin_pkg::OP_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(stsin_pkg::OP_W);

    logic                              busy_reg;
    logic                              done_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [stsin_pkg::DIV_W-1:0]       rem_reg;
    logic [stsin_pkg::DIV_W-1:0]       dvs_reg;
    logic [stsin_pkg::OP_W-1:0]        quo_reg;
    logic [stsin_pkg::DIV_W:0]         shifted;
    logic [stsin_pkg::DIV_W:0]         diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[stsin_pkg::OP_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    done_reg <= 1'b0;
            end
            else
                done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            if (!diff[stsin_pkg::DIV_W])
            begin
                rem_reg <= diff[stsin_pkg::DIV_W-1:0];
                quo_reg <= {quo_reg[stsin_pkg::OP_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[stsin_pkg::DIV_W-1:0];
                quo_reg <= {quo_reg[stsin_pkg::OP_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### tb/sine_series_checker.sv
`timescale 1ns / 100ps
// Checker for sine_taylor_series: watches the angle, result and register ports, predicts
// each series sum and compares the sum, step count and limit flag as one record. Depends on stsin_pkg.
module sine_series_checker
    import stsin_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic signed [ANGLE_W-1:0] angle,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic signed [VAL_W-1:0]   series_sum,
    input  logic [LIM_W-1:0]          steps_taken,
    input  logic                      hit_limit,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    input  logic                      pready,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic signed [VAL_W-1:0] sum;
        logic [LIM_W-1:0]        steps;
        logic                    at_limit;
    } sine_result_t;

    localparam longint      SUM_HI   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint      SUM_LO   = -SUM_HI - 1;
    localparam logic [63:0] TERM_CAP = 64'h0000_7FFF_FFFF_FFFF;

    logic [THR_W-1:0] threshold;
    logic [LIM_W-1:0] term_limit;
    sine_result_t     sums_due [$];
    sine_result_t     want;
    sine_result_t     seen;
    int               errors;

    function automatic sine_result_t sine_series(input logic signed [ANGLE_W-1:0] x,
                                                 input logic [THR_W-1:0] thr,
                                                 input logic [LIM_W-1:0] lim);
        logic [127:0] prod;
        logic [127:0] shifted;
        logic [63:0]  mag;
        logic [63:0]  h;
        logic [63:0]  eps;
        logic [63:0]  m;
        logic [63:0]  q;
        logic [63:0]  d;
        logic [63:0]  limit;
        logic [63:0]  k;
        longint       term;
        longint       acc;
        logic         was_neg;
        sine_result_t r;
        term = longint'(x);
        acc  = term;
        if (FRAC_BITS >= 32)
            eps = 64'(thr) << (FRAC_BITS - 32);
        else
            eps = 64'(thr) >> (32 - FRAC_BITS);
        limit = (lim == '0) ? 64'd1 : 64'(lim);
        mag = (term < 0) ? -term : term;
        prod = {64'd0, mag} * {64'd0, mag};
        shifted = prod >> (FRAC_BITS + 1);
        h = (|shifted[127:64]) ? '1 : shifted[63:0];
        k = 0;
        do
        begin
            was_neg = term < 0;
            k = k + 1;
            d = k * (2 * k + 1);
            prod = {64'd0, mag} * {64'd0, h};
            shifted = prod >> FRAC_BITS;
            m = (|shifted[127:64]) ? '1 : shifted[63:0];
            q = m / d;
            if (q > TERM_CAP)
                q = TERM_CAP;
            term = was_neg ? longint'(q) : -longint'(q);
            acc = acc + term;
            if (acc > SUM_HI)
                acc = SUM_HI;
            if (acc < SUM_LO)
                acc = SUM_LO;
            mag = (term < 0) ? -term : term;
        end
        while (mag > eps && k < limit);
        r.sum      = acc[VAL_W-1:0];
        r.steps    = k[LIM_W-1:0];
        r.at_limit = (k == limit);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold  <= THR_RST;
            term_limit <= LIM_RST;
            sums_due.delete();
            errors = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[ADDR_W-1] == REG_THR)
                    threshold <= pwdata[THR_W-1:0];
                else
                    term_limit <= pwdata[LIM_W-1:0];
            end
            if (out_valid && !out_stall)
            begin
                seen = '{series_sum, steps_taken, hit_limit};
                if (sums_due.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("%t: unexpected result sum %0d steps %0d limit %0b",
                                 $realtime, seen.sum, seen.steps, seen.at_limit);
                end
                else
                begin
                    want = sums_due.pop_front();
                    if (seen !== want)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("%t: mismatch expected sum %0d steps %0d limit %0b, got sum %0d steps %0d limit %0b",
                                     $realtime, want.sum, want.steps, want.at_limit,
                                     seen.sum, seen.steps, seen.at_limit);
                    end
                end
            end
            if (in_valid && !in_stall)
                sums_due.push_back(sine_series(angle, threshold, term_limit));
            fail_count <= errors;
            pending    <= sums_due.size();
        end
    end

endmodule

### tb/tb_sine_taylor_series.sv
`timescale 1ns / 100ps
// Top of the sine_taylor_series testbench: clock, reset, angle and register stimulus,
// result back-pressure and the verdict. Depends on stsin_pkg and sine_series_checker.
module tb_sine_taylor_series;
    import stsin_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam int PHASE_ITEMS = 50;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [ANGLE_W-1:0] angle;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [VAL_W-1:0]   series_sum;
    logic [LIM_W-1:0]          steps_taken;
    logic                      hit_limit;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    int                        fail_count;
    int                        pending;
    int                        idle_cycles;
    logic signed [ANGLE_W-1:0] corner_angles [$];

    sine_taylor_series dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .angle       (angle),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .series_sum  (series_sum),
        .steps_taken (steps_taken),
        .hit_limit   (hit_limit),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    sine_series_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .angle       (angle),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .series_sum  (series_sum),
        .steps_taken (steps_taken),
        .hit_limit   (hit_limit),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 6);
        return $urandom_range(50, 600);
    endfunction

    function automatic logic signed [ANGLE_W-1:0] random_angle();
        logic [63:0] raw;
        logic [63:0] span;
        int          pick;
        pick = $urandom_range(0, 9);
        raw  = {$urandom, $urandom};
        if (pick < 6)
        begin
            span = (64'd10 << 32) + 64'd1;
            raw  = raw % span;
            return pick[0] ? -raw[ANGLE_W-1:0] : raw[ANGLE_W-1:0];
        end
        if (pick < 8)
            return raw[ANGLE_W-1:0];
        return {{(ANGLE_W-33){raw[33]}}, raw[32:0]};
    endfunction

    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_angle(input logic signed [ANGLE_W-1:0] value);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        angle    <= value;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // let the checker count the last transaction before waiting on it
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (16) @(posedge clk);
    endtask

    // hold the result side back in runs, some long enough to span a whole series
    initial
    begin
        int r;
        int run;
        out_stall <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                out_stall <= 1'b0;
                run = $urandom_range(1, 300);
            end
            else if (r < 90)
            begin
                out_stall <= 1'b1;
                run = $urandom_range(1, 8);
            end
            else
            begin
                out_stall <= 1'b1;
                run = $urandom_range(100, 3000);
            end
            repeat (run) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [DATA_W-1:0] thr_v;
        logic [DATA_W-1:0] lim_v;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        angle       <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        corner_angles = '{
            37'sd0, 37'sd1, -37'sd1,
            37'sh0F_FFFF_FFFF, -37'sd68719476736,
            37'sd42949672960, -37'sd42949672960,
            37'sd42949672961, -37'sd42949672961,
            37'sd4294967296, -37'sd4294967296, 37'sd2147483648,
            37'sd6746518852, -37'sd6746518852, 37'sd13493037705,
            37'sd92681, 37'sd92682,
            37'sh0A_AAAA_AAAA, 37'sh15_5555_5555,
            37'sd12884901888, -37'sd30064771072
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_angles[i])
            send_angle(corner_angles[i]);
        drain_results();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    thr_v = 32'd0;
                    lim_v = 32'd65535;
                end
                1:
                begin
                    thr_v = 32'hFFFF_FFFF;
                    lim_v = 32'd0;
                end
                2:
                begin
                    thr_v = 32'd1;
                    lim_v = 32'd1;
                end
                3:
                begin
                    thr_v = 32'd4295;
                    lim_v = 32'd65535;
                end
                4:
                begin
                    thr_v = $urandom;
                    lim_v = $urandom_range(1, 12);
                end
                default:
                begin
                    thr_v = $urandom_range(0, 1000);
                    lim_v = $urandom_range(1, 65535);
                end
            endcase
            write_reg(REG_THR, thr_v);
            write_reg(REG_LIM, lim_v);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_angle(random_angle());
            drain_results();
        end

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
